// File: hw/rtl/vcodec_pkg.sv
package vcodec_pkg;

	// operation select on the request channel
	localparam logic OP_DECODE = 1'b0;
	localparam logic OP_ENCODE = 1'b1;

	// result kinds
	typedef enum logic [1:0] {
		KIND_ENC = 2'd0,
		KIND_DEC = 2'd1,
		KIND_ERR = 2'd2
	} kind_t;

	// varint constants
	localparam logic [7:0] Low7Mask  = 8'h7F;
	localparam logic [7:0] ContMask  = 8'h80;
	localparam logic [3:0] MaxShort  = 4'd5;
	localparam logic [3:0] MaxLong   = 4'd10;
	localparam logic [6:0] GroupBits = 7'd7;

	// controller states, one-hot
	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_ENC  = 2'b10
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic dec_go;    // take one decode byte
		logic enc_load;  // load a value to encode
		logic enc_emit;  // emit the next encoded byte
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic slot_free; // output register can take a result this cycle
		logic enc_last;  // next encoded byte is the last one
	} sts_t;

endpackage

// File: hw/rtl/vcodec_ctrl.sv
module vcodec_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               op,
	input  vcodec_pkg::sts_t   sts,
	output vcodec_pkg::cmd_t   cmd
);
	import vcodec_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   fire;

	// requests only in idle, and only when the output register can take a result
	assign in_ready = (state_q == ST_IDLE) && sts.slot_free;
	assign fire     = in_valid && in_ready;

	always_comb begin
		state_d      = state_q;
		cmd.dec_go   = 1'b0;
		cmd.enc_load = 1'b0;
		cmd.enc_emit = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (fire) begin
					if (op == OP_ENCODE) begin
						cmd.enc_load = 1'b1;
						state_d      = ST_ENC;
					end else begin
						cmd.dec_go = 1'b1;
					end
				end
			end
			ST_ENC: begin
				if (sts.slot_free) begin
					cmd.enc_emit = 1'b1;
					if (sts.enc_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// no request is taken while a run of encoded bytes is going out
	a_no_accept_in_enc: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ENC) |-> !in_ready)
		else $error("request accepted during encode run");

	// an encode request always starts a run
	a_load_starts_run: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.enc_load |=> (state_q == ST_ENC))
		else $error("encode load did not enter run state");

endmodule

// File: hw/rtl/vcodec_dp.sv
module vcodec_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  vcodec_pkg::cmd_t    cmd,
	output vcodec_pkg::sts_t    sts,
	input  logic                long_form,
	input  logic [7:0]          in_byte,
	input  logic signed [63:0]  in_value,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          kind,
	output logic [7:0]          out_byte,
	output logic                out_last,
	output logic signed [63:0]  out_value,
	output logic [3:0]          byte_count
);
	import vcodec_pkg::*;

	// decode state
	logic [63:0] acc_q;
	logic [3:0]  seen_q;
	logic        form_q;

	// encode state
	logic [63:0] sh_q;
	logic [3:0]  cnt_q;

	// output register
	logic        ovalid_q;
	kind_t       kind_q;
	logic [7:0]  byte_q;
	logic        last_q;
	logic [63:0] value_q;
	logic [3:0]  count_q;

	// decode path
	logic        lf_eff;
	logic [3:0]  limit;
	logic        dec_err;
	logic        dec_more;
	logic        dec_done;
	logic [6:0]  shamt;
	logic [63:0] grp;
	logic [63:0] acc_or;
	logic [63:0] acc_new;
	logic [63:0] dec_val;
	logic [3:0]  seen_inc;

	// encode path
	logic        enc_cont;
	logic [7:0]  enc_byte;

	assign lf_eff   = (seen_q == 4'd0) ? long_form : form_q;
	assign limit    = lf_eff ? MaxLong : MaxShort;
	assign dec_err  = (seen_q >= limit);
	assign dec_more = |(in_byte & ContMask);
	assign dec_done = dec_err || !dec_more;
	assign shamt    = 7'(seen_q) * GroupBits;
	assign grp      = {56'd0, in_byte & Low7Mask};
	assign acc_or   = acc_q | (grp << shamt[5:0]);
	assign acc_new  = lf_eff ? acc_or : {32'd0, acc_or[31:0]};
	assign dec_val  = lf_eff ? acc_new : {{32{acc_new[31]}}, acc_new[31:0]};
	assign seen_inc = seen_q + 4'd1;

	assign enc_cont = (sh_q[63:7] != 57'd0);
	assign enc_byte = {1'b0, sh_q[6:0]} | (enc_cont ? ContMask : 8'h00);

	assign sts.slot_free = !ovalid_q || out_ready;
	assign sts.enc_last  = !enc_cont;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			seen_q <= '0;
			form_q <= 1'b0;
		end else if (cmd.dec_go) begin
			if (dec_done) begin
				acc_q  <= '0;
				seen_q <= '0;
				form_q <= 1'b0;
			end else begin
				acc_q  <= acc_new;
				seen_q <= seen_inc;
				form_q <= lf_eff;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.enc_load) begin
			cnt_q <= '0;
		end else if (cmd.enc_emit) begin
			cnt_q <= cnt_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.enc_load) begin
			sh_q <= long_form ? 64'(in_value) : {32'd0, in_value[31:0]};
		end else if (cmd.enc_emit) begin
			sh_q <= sh_q >> GroupBits;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if ((cmd.dec_go && dec_done) || cmd.enc_emit) begin
			ovalid_q <= 1'b1;
		end else if (out_ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.enc_emit) begin
			kind_q  <= KIND_ENC;
			byte_q  <= enc_byte;
			last_q  <= !enc_cont;
			value_q <= '0;
			count_q <= cnt_q + 4'd1;
		end else if (cmd.dec_go && dec_done) begin
			byte_q <= '0;
			last_q <= 1'b0;
			if (dec_err) begin
				kind_q  <= KIND_ERR;
				value_q <= '0;
				count_q <= '0;
			end else begin
				kind_q  <= KIND_DEC;
				value_q <= dec_val;
				count_q <= seen_inc;
			end
		end
	end

	assign out_valid  = ovalid_q;
	assign kind       = kind_q;
	assign out_byte   = byte_q;
	assign out_last   = last_q;
	assign out_value  = $signed(value_q);
	assign byte_count = count_q;

	a_seen_bound: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q <= MaxLong)
		else $error("decode byte count out of range");

	a_short_acc: assert property (@(posedge clk) disable iff (!arst_n)
		!form_q |-> (acc_q[63:32] == 32'd0))
		else $error("short form accumulator above bit 31");

	a_err_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.dec_go && dec_err) |=> (seen_q == 4'd0 && acc_q == 64'd0))
		else $error("decode state not cleared after error");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(ovalid_q && !out_ready) |-> !(cmd.enc_emit || (cmd.dec_go && dec_done)))
		else $error("result written over a pending result");

endmodule

// File: hw/rtl/varint_codec_32_64_top.sv
// channel   | handshake            | payload
// ----------+----------------------+-----------------------------------------------
// request   | in_valid / in_ready  | op, long_form, in_byte, in_value
// result    | out_valid / out_ready| kind, out_byte, out_last, out_value, byte_count
//
// a decode request's result (if any) appears the cycle after it is taken
// an encode request gives n output bytes (1..10) from the shift register in the
//   datapath, one per cycle unless the result stalls; no request is taken meanwhile
// arst_n clears the decode accumulator, byte count, latched form and the fsm
// a stalled result holds in the output register; the next request is still
//   taken in the cycle the pending result leaves
module varint_codec_32_64_top (
	input  logic               clk,
	input  logic               arst_n,
	// request channel
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               op,
	input  logic               long_form,
	input  logic [7:0]         in_byte,
	input  logic signed [63:0] in_value,
	// result channel
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         kind,
	output logic [7:0]         out_byte,
	output logic               out_last,
	output logic signed [63:0] out_value,
	output logic [3:0]         byte_count
);
	import vcodec_pkg::*;

	// command and status between the fsm and the datapath
	cmd_t cmd;
	sts_t sts;

	// sequencer: idle / encode run
	vcodec_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.op       (op),
		.sts      (sts),
		.cmd      (cmd)
	);

	// accumulator, encode shifter and output register
	vcodec_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.long_form  (long_form),
		.in_byte    (in_byte),
		.in_value   (in_value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.kind       (kind),
		.out_byte   (out_byte),
		.out_last   (out_last),
		.out_value  (out_value),
		.byte_count (byte_count)
	);

endmodule

// File: bench/varint_codec_32_64_top_tb.sv
`timescale 1ns / 100ps

module varint_codec_32_64_top_tb;
	import vcodec_pkg::*;

	localparam int RUN_ITEMS   = 460;
	localparam int CYCLE_LIMIT = 400000;
	localparam int TAIL_CYCLES = 20;

	// one request as the driver presents it
	typedef struct {
		logic        op;
		logic        long_form;
		logic [7:0]  data;
		logic [63:0] value;
		bit          drain_first; // hold until no result is outstanding
	} codec_req_t;

	// one result the block owes us
	typedef struct {
		kind_t       kind;
		logic [7:0]  code;
		logic        last;
		logic [63:0] value;
		logic [3:0]  count;
	} codec_res_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        op = OP_DECODE;
	logic        long_form = 1'b0;
	logic [7:0]  in_byte = 8'h00;
	logic signed [63:0] in_value = 64'sd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  kind;
	logic [7:0]  out_byte;
	logic        out_last;
	logic signed [63:0] out_value;
	logic [3:0]  byte_count;

	codec_req_t requests_to_send[$];
	codec_res_t results_due[$];

	// shadow decode state
	logic [63:0] dec_acc = '0;
	logic [3:0]  dec_count = '0;
	logic        dec_long = 1'b0;

	int mismatches = 0;
	int reqs_taken = 0;
	int cycles = 0;
	bit req_taken = 1'b0;

	varint_codec_32_64_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.long_form(long_form),
		.in_byte(in_byte),
		.in_value(in_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.out_byte(out_byte),
		.out_last(out_last),
		.out_value(out_value),
		.byte_count(byte_count)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic codec_res_t mk_res(kind_t k, logic [7:0] c, logic l,
			logic [63:0] v, logic [3:0] n);
		codec_res_t r;
		r.kind  = k;
		r.code  = c;
		r.last  = l;
		r.value = v;
		r.count = n;
		return r;
	endfunction

	// work out what one accepted request produces and queue it
	task automatic leb128_predict(logic req_op, logic lf, logic [7:0] b, logic [63:0] val);
		logic [3:0]  limit;
		logic [63:0] v;
		logic [7:0]  grp;
		int          n;
		if (req_op == OP_DECODE) begin
			// form is latched on the first byte of a value only
			if (dec_count == 4'd0)
				dec_long = lf;
			limit = dec_long ? MaxLong : MaxShort;
			if (dec_count >= limit) begin
				// one byte past the limit: error whatever bit 7 says
				dec_acc   = '0;
				dec_count = '0;
				dec_long  = 1'b0;
				results_due.push_back(mk_res(KIND_ERR, 8'h00, 1'b0, 64'd0, 4'd0));
			end else begin
				// bits shifted past the top are simply lost
				dec_acc = dec_acc | ({57'd0, b[6:0]} << (7 * dec_count));
				if (!dec_long)
					dec_acc[63:32] = '0;
				dec_count = dec_count + 4'd1;
				if (!b[7]) begin
					v = dec_acc;
					if (!dec_long)
						v = {{32{v[31]}}, v[31:0]};
					results_due.push_back(mk_res(KIND_DEC, 8'h00, 1'b0, v, dec_count));
					dec_acc   = '0;
					dec_count = '0;
					dec_long  = 1'b0;
				end
			end
		end else begin
			// encode leaves the decode state alone
			v = lf ? val : {32'd0, val[31:0]};
			n = 0;
			do begin
				grp = {1'b0, v[6:0]};
				v = v >> 7;
				if (v != 64'd0)
					grp[7] = 1'b1;
				results_due.push_back(mk_res(KIND_ENC, grp, v == 64'd0, 64'd0,
					4'(n + 1)));
				n++;
			end while (v != 64'd0 && n < 10);
		end
	endtask

	task automatic add_req(logic req_op, logic lf, logic [7:0] b, logic [63:0] val,
			bit drain);
		codec_req_t r;
		r.op          = req_op;
		r.long_form   = lf;
		r.data        = b;
		r.value       = val;
		r.drain_first = drain;
		requests_to_send.push_back(r);
	endtask

	// driver: inputs move on the falling edge only
	always @(negedge clk) begin
		int  mode;
		bit  send_idle;
		bit  recv_stall;
		mode = (reqs_taken / 40) % 4;
		case (mode)
			1: begin
				send_idle  = $urandom_range(99) < 78;
				recv_stall = 1'b0;
			end
			2: begin
				send_idle  = 1'b0;
				recv_stall = $urandom_range(99) < 78;
			end
			3: begin
				send_idle  = $urandom_range(99) < 13;
				recv_stall = $urandom_range(99) < 13;
			end
			default: begin
				send_idle  = 1'b0;
				recv_stall = 1'b0;
			end
		endcase
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= !recv_stall;
			// a request still waiting keeps its payload untouched
			if (!(in_valid && !req_taken)) begin
				if (requests_to_send.size() != 0 && !send_idle &&
						!(requests_to_send[0].drain_first && results_due.size() != 0)) begin
					codec_req_t r;
					r = requests_to_send.pop_front();
					op        <= r.op;
					long_form <= r.long_form;
					in_byte   <= r.data;
					in_value  <= r.value;
					in_valid  <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: both channels sampled on the rising edge
	always @(posedge clk) begin
		codec_res_t e;
		if (arst_n) begin
			req_taken <= in_valid && in_ready;
			// predict first; a result leaving now is never from this request
			if (in_valid && in_ready) begin
				leb128_predict(op, long_form, in_byte, in_value);
				reqs_taken <= reqs_taken + 1;
			end
			if (out_valid && out_ready) begin
				if (results_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: kind=%0d byte=%h last=%b value=%h count=%0d",
							kind, out_byte, out_last, out_value, byte_count);
				end else begin
					e = results_due.pop_front();
					if (kind !== e.kind || out_byte !== e.code || out_last !== e.last ||
							out_value !== e.value || byte_count !== e.count) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"result mismatch: exp kind=%0d byte=%h last=%b value=%h",
								" count=%0d, got kind=%0d byte=%h last=%b value=%h count=%0d"},
								e.kind, e.code, e.last, e.value, e.count,
								kind, out_byte, out_last, out_value, byte_count);
					end
				end
			end
		end
	end

	initial begin
		int          runs;
		int          sel;
		int          n;
		int          lim;
		int          w;
		logic        lf;
		logic [7:0]  b;
		logic [63:0] v;
		bit          drain;

		// directed: single bytes in both forms
		add_req(OP_DECODE, 1'b0, 8'h00, rand64(), 1'b0);
		add_req(OP_DECODE, 1'b1, 8'h7F, rand64(), 1'b0);
		// encode slipped into the middle of a decode; form stays short
		add_req(OP_DECODE, 1'b0, 8'h80, rand64(), 1'b0);
		add_req(OP_ENCODE, 1'b1, 8'hA5, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
		add_req(OP_DECODE, 1'b1, 8'h01, rand64(), 1'b0);
		// five short bytes, form flips ignored, top bits of the fifth dropped
		add_req(OP_DECODE, 1'b0, 8'hFF, rand64(), 1'b0);
		add_req(OP_DECODE, 1'b1, 8'hFF, rand64(), 1'b0);
		add_req(OP_DECODE, 1'b1, 8'hFF, rand64(), 1'b0);
		add_req(OP_DECODE, 1'b0, 8'hFF, rand64(), 1'b0);
		add_req(OP_DECODE, 1'b1, 8'h7F, rand64(), 1'b0);
		// sixth short byte is an error even without a continuation bit... here with one
		for (int i = 0; i < 5; i++)
			add_req(OP_DECODE, 1'b0, 8'h80, rand64(), 1'b0);
		add_req(OP_DECODE, 1'b0, 8'hFF, rand64(), 1'b0);
		// encode extremes
		add_req(OP_ENCODE, 1'b0, 8'h00, 64'd0, 1'b0);
		add_req(OP_ENCODE, 1'b0, 8'hFF, 64'h8000_0000_FFFF_FFFF, 1'b0);
		add_req(OP_ENCODE, 1'b1, 8'h00, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
		add_req(OP_ENCODE, 1'b1, 8'h00, 64'h8000_0000_0000_0000, 1'b0);
		add_req(OP_ENCODE, 1'b1, 8'h00, 64'h0000_0000_0000_007F, 1'b0);
		add_req(OP_ENCODE, 1'b0, 8'h00, 64'h0000_0000_0000_0080, 1'b0);

		// random: mostly whole varints, some lone stray bytes
		runs = 0;
		while (requests_to_send.size() < RUN_ITEMS) begin
			drain = (runs == 0) || (runs == 120);
			sel = $urandom_range(99);
			if (sel < 58) begin
				lf  = 1'($urandom_range(1));
				lim = lf ? 10 : 5;
				case ($urandom_range(9))
					0: n = lim + 1;   // runs past the limit
					1: n = lim;       // longest legal value
					default: n = $urandom_range(lim, 1);
				endcase
				for (int i = 0; i < n; i++) begin
					b = 8'($urandom);
					if (i < n - 1)
						b[7] = 1'b1;
					else if (n <= lim)
						b[7] = 1'b0;
					add_req(OP_DECODE, (i == 0) ? lf : 1'($urandom_range(1)), b, rand64(),
						drain && i == 0);
				end
			end else if (sel < 94) begin
				lf = 1'($urandom_range(1));
				w  = $urandom_range(64);
				v  = rand64();
				if (w < 64)
					v = v & ((64'd1 << w) - 64'd1);
				// short form must ignore whatever sits in the upper half
				if (!lf)
					v[63:32] = $urandom;
				add_req(OP_ENCODE, lf, 8'($urandom), v, drain);
			end else begin
				add_req(OP_DECODE, 1'($urandom_range(1)), 8'($urandom), rand64(), drain);
			end
			runs++;
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (requests_to_send.size() != 0 || in_valid)
			@(posedge clk);
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
